[hw/rtl/lar_pkg.sv]
// lar_pkg: shared widths, types and codes for the look-at rotation basis.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package lar_pkg;

  // operand widths
  localparam int VW   = 24;          // Q12.12 input vector component
  localparam int DW   = VW + 1;      // target minus position
  localparam int UW   = 16;          // Q1.14 unit component
  localparam int PW   = VW + UW;     // one cross product term
  localparam int CW   = PW + 2;      // cross product component
  localparam int AW   = 16;          // magnitude after range shift
  localparam int KW   = 6;           // range shift amount
  localparam int SQW  = 2 * AW;      // squared magnitude
  localparam int SW   = SQW + 2;     // sum of three squares
  localparam int RW   = SW + 1;      // divider partial remainder
  localparam int QDW  = 31;          // floor(2^30 * a^2 / S)
  localparam int RTW  = 16;          // integer square root of that
  localparam int QW   = 15;          // rounded unit magnitude

  // pipeline depths of one normalizer lane
  localparam int DIV_N    = QDW;
  localparam int SQ_N     = RTW;
  localparam int LANE_LAT = DIV_N + SQ_N;

  localparam logic signed [UW-1:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [DW-1:0] dir_t;
  typedef logic signed [UW-1:0] unit_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] wide_t;

  typedef enum logic [1:0] {
    CFG_POS_X = 2'd0,
    CFG_POS_Y = 2'd1,
    CFG_POS_Z = 2'd2
  } cfg_idx_t;

  // data that rides along the pipeline with each word
  typedef struct packed {
    logic            mode;
    vec_t  [2:0]     up;
    unit_t [2:0]     fwd;
    unit_t [2:0]     rgt;
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/look_at_rotation_basis.sv]
// look_at_rotation_basis: top level, 3x3 rotation part of a look-at matrix.
// Uses lar_pkg, lar_cross and lar_unitize.
//
// Takes one word per clock (busy is always low) and returns one result word
// per input word, in order, shown for one cycle with out_strobe. The
// receiver cannot stall the pipeline. The pipeline holds three normalizers
// in series, each a 31-stage restoring divider and a 16-stage square root
// per component, plus two cross products.
// Position registers are written through cfg_* (ready always high) and must
// only change while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module look_at_rotation_basis (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  lar_pkg::vec_t         in_vec_x,
  input  lar_pkg::vec_t         in_vec_y,
  input  lar_pkg::vec_t         in_vec_z,
  input  lar_pkg::vec_t         in_up_x,
  input  lar_pkg::vec_t         in_up_y,
  input  lar_pkg::vec_t         in_up_z,
  output logic                  out_strobe,
  output lar_pkg::unit_t        out_right_x,
  output lar_pkg::unit_t        out_right_y,
  output lar_pkg::unit_t        out_right_z,
  output lar_pkg::unit_t        out_upout_x,
  output lar_pkg::unit_t        out_upout_y,
  output lar_pkg::unit_t        out_upout_z,
  output lar_pkg::unit_t        out_fwd_x,
  output lar_pkg::unit_t        out_fwd_y,
  output lar_pkg::unit_t        out_fwd_z,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  lar_pkg::vec_t         cfg_data
);
  import lar_pkg::*;

  vec_t          pos_r [3];
  vec_t  [2:0]   vec_in;
  dir_t  [2:0]   dir_nxt;
  logic          v0_r;
  dir_t  [2:0]   dir0_r;
  side_t         side0_r;
  side_t         side_nxt;

  wide_t [2:0]   ca;
  logic          va;
  unit_t [2:0]   fa;
  side_t         sa, sa_f;

  logic          vxb;
  wide_t [2:0]   cb;
  side_t         sxb;
  logic          vb;
  unit_t [2:0]   rb, rfix;
  side_t         sb, sb_fix;

  vec_t  [2:0]   fwd_ext;
  logic          vxc;
  wide_t [2:0]   cc;
  side_t         sxc;
  logic          vc;
  unit_t [2:0]   uc, ufix;
  side_t         sc;

  logic          out_strobe_r;
  unit_t [2:0]   rgt_r, upo_r, fwd_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) pos_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POS_X: pos_r[0] <= cfg_data;
        CFG_POS_Y: pos_r[1] <= cfg_data;
        CFG_POS_Z: pos_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // look direction, target minus position in target mode
  always_comb begin
    vec_in[0] = in_vec_x;
    vec_in[1] = in_vec_y;
    vec_in[2] = in_vec_z;
    for (int i = 0; i < 3; i++) begin
      dir_nxt[i] = in_mode ? DW'(vec_in[i]) - DW'(pos_r[i]) : DW'(vec_in[i]);
    end
    side_nxt       = '0;
    side_nxt.mode  = in_mode;
    side_nxt.up[0] = in_up_x;
    side_nxt.up[1] = in_up_y;
    side_nxt.up[2] = in_up_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dir0_r  <= dir_nxt;
    side0_r <= side_nxt;
  end

  // normalize the look vector
  always_comb begin
    for (int i = 0; i < 3; i++) ca[i] = CW'(dir0_r[i]);
  end

  lar_unitize u_unit_fwd (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v0_r),
    .c_i     (ca),
    .side_i  (side0_r),
    .valid_o (va),
    .u_o     (fa),
    .side_o  (sa)
  );

  always_comb begin
    sa_f     = sa;
    sa_f.fwd = fa;
  end

  // right = norm(up x fwd)
  lar_cross u_cross_rgt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (va),
    .a_i     (sa.up),
    .b_i     (fa),
    .side_i  (sa_f),
    .valid_o (vxb),
    .c_o     (cb),
    .side_o  (sxb)
  );

  lar_unitize u_unit_rgt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vxb),
    .c_i     (cb),
    .side_i  (sxb),
    .valid_o (vb),
    .u_o     (rb),
    .side_o  (sb)
  );

  // zero right in direction mode becomes +x
  always_comb begin
    rfix = rb;
    if (!sb.mode && rb[0] == '0 && rb[1] == '0 && rb[2] == '0) begin
      rfix[0] = ONE_Q14;
    end
    sb_fix     = sb;
    sb_fix.rgt = rfix;
    for (int i = 0; i < 3; i++) fwd_ext[i] = VW'(sb.fwd[i]);
  end

  // upout = norm(fwd x right)
  lar_cross u_cross_upo (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vb),
    .a_i     (fwd_ext),
    .b_i     (rfix),
    .side_i  (sb_fix),
    .valid_o (vxc),
    .c_o     (cc),
    .side_o  (sxc)
  );

  lar_unitize u_unit_upo (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (vxc),
    .c_i     (cc),
    .side_i  (sxc),
    .valid_o (vc),
    .u_o     (uc),
    .side_o  (sc)
  );

  // zero upout in direction mode becomes +y
  always_comb begin
    ufix = uc;
    if (!sc.mode && uc[0] == '0 && uc[1] == '0 && uc[2] == '0) begin
      ufix[1] = ONE_Q14;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vc;
    end
  end

  always_ff @(posedge clk) begin
    rgt_r <= sc.rgt;
    upo_r <= ufix;
    fwd_r <= sc.fwd;
  end

  assign out_strobe  = out_strobe_r;
  assign out_right_x = rgt_r[0];
  assign out_right_y = rgt_r[1];
  assign out_right_z = rgt_r[2];
  assign out_upout_x = upo_r[0];
  assign out_upout_y = upo_r[1];
  assign out_upout_z = upo_r[2];
  assign out_fwd_x   = fwd_r[0];
  assign out_fwd_y   = fwd_r[1];
  assign out_fwd_z   = fwd_r[2];

endmodule

`default_nettype wire

[hw/rtl/lar_lane.sv]
// lar_lane: one component of a normalizer, a pipelined restoring divide
// followed by a pipelined integer square root. Uses lar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lar_lane (
  input  logic                    clk,
  input  logic [lar_pkg::SQW-1:0] a_sq_i,
  input  logic [lar_pkg::SW-1:0]  sum_i,
  output logic [lar_pkg::QW-1:0]  q_o
);
  import lar_pkg::*;

  logic [RW-1:0]   rem_r   [DIV_N];
  logic [QDW-1:0]  quo_r   [DIV_N];
  logic [SW-1:0]   dvs_r   [DIV_N];
  logic [RW-1:0]   rem_nxt [DIV_N];
  logic [QDW-1:0]  quo_nxt [DIV_N];
  logic [RW-1:0]   part    [DIV_N];
  logic [SW-1:0]   dvs     [DIV_N];
  logic [QDW-1:0]  qin     [DIV_N];
  logic            take    [DIV_N];

  logic [QDW-1:0]  rad_r    [SQ_N];
  logic [RTW-1:0]  root_r   [SQ_N];
  logic [RTW-1:0]  root_nxt [SQ_N];
  logic [QDW-1:0]  rad      [SQ_N];
  logic [RTW-1:0]  rin      [SQ_N];
  logic [RTW-1:0]  trial    [SQ_N];
  logic [SQW-1:0]  tsq      [SQ_N];

  logic [RTW:0]    rnd;

  // divide a^2 * 2^30 by S, one quotient bit per stage
  always_comb begin
    part[0] = RW'(a_sq_i);
    dvs[0]  = sum_i;
    qin[0]  = '0;
    for (int i = 1; i < DIV_N; i++) begin
      part[i] = {rem_r[i-1][RW-2:0], 1'b0};
      dvs[i]  = dvs_r[i-1];
      qin[i]  = quo_r[i-1];
    end
    for (int i = 0; i < DIV_N; i++) begin
      take[i]    = (dvs[i] != '0) && (part[i] >= RW'(dvs[i]));
      rem_nxt[i] = take[i] ? part[i] - RW'(dvs[i]) : part[i];
      quo_nxt[i] = {qin[i][QDW-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_N; i++) begin
      rem_r[i] <= rem_nxt[i];
      quo_r[i] <= quo_nxt[i];
      dvs_r[i] <= dvs[i];
    end
  end

  // square root of the quotient, one root bit per stage
  always_comb begin
    rad[0] = quo_r[DIV_N-1];
    rin[0] = '0;
    for (int j = 1; j < SQ_N; j++) begin
      rad[j] = rad_r[j-1];
      rin[j] = root_r[j-1];
    end
    for (int j = 0; j < SQ_N; j++) begin
      trial[j]    = rin[j] | (RTW'(1) << (RTW - 1 - j));
      tsq[j]      = SQW'(trial[j]) * SQW'(trial[j]);
      root_nxt[j] = (tsq[j] <= SQW'(rad[j])) ? trial[j] : rin[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SQ_N; j++) begin
      rad_r[j]  <= rad[j];
      root_r[j] <= root_nxt[j];
    end
  end

  // largest q with 2q-1 <= root
  assign rnd = {1'b0, root_r[SQ_N-1]} + (RTW+1)'(1);
  assign q_o = rnd[QW:1];

endmodule

`default_nettype wire

[hw/rtl/lar_unitize.sv]
// lar_unitize: normalizes a wide signed vector to Q1.14, rounded to nearest.
// Uses lar_pkg and three lar_lane instances.
`timescale 1ns / 1ps
`default_nettype none

module lar_unitize (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  input  lar_pkg::wide_t [2:0]       c_i,
  input  lar_pkg::side_t             side_i,
  output logic                       valid_o,
  output lar_pkg::unit_t [2:0]       u_o,
  output lar_pkg::side_t             side_o
);
  import lar_pkg::*;

  logic                v1_r, v2_r, v3_r, v4_r;
  logic [CW-1:0]       mag1_r [3];
  logic [CW-1:0]       max1_r;
  logic [2:0]          neg1_r, neg2_r, neg3_r, neg4_r;
  side_t               side1_r, side2_r, side3_r, side4_r;
  logic [AW-1:0]       a2_r [3];
  logic [SQW-1:0]      sq3_r [3];
  logic [SQW-1:0]      sq4_r [3];
  logic [SW-1:0]       sum4_r;

  logic [CW-1:0]       mag_nxt [3];
  logic [2:0]          neg_nxt;
  logic [CW-1:0]       max_nxt;
  logic [KW-1:0]       top_bit;
  logic [KW-1:0]       shift;

  logic                dv_r    [LANE_LAT];
  logic [2:0]          dneg_r  [LANE_LAT];
  side_t               dside_r [LANE_LAT];

  logic [QW-1:0]       q      [3];
  logic                vout_r;
  unit_t [2:0]         u_r;
  side_t               sout_r;

  // magnitudes, signs and the largest magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = c_i[i][CW-1];
      mag_nxt[i] = neg_nxt[i] ? CW'(-c_i[i]) : CW'(c_i[i]);
    end
    max_nxt = mag_nxt[0];
    if (mag_nxt[1] > max_nxt) max_nxt = mag_nxt[1];
    if (mag_nxt[2] > max_nxt) max_nxt = mag_nxt[2];
  end

  // range shift so the largest magnitude fits 16 bits
  always_comb begin
    top_bit = '0;
    for (int b = 0; b < CW; b++) begin
      if (max1_r[b]) top_bit = KW'(b);
    end
    shift = (top_bit > KW'(AW - 1)) ? top_bit - KW'(AW - 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag1_r[i] <= mag_nxt[i];
      a2_r[i]   <= AW'(mag1_r[i] >> shift);
      sq3_r[i]  <= SQW'(a2_r[i]) * SQW'(a2_r[i]);
      sq4_r[i]  <= sq3_r[i];
    end
    max1_r  <= max_nxt;
    sum4_r  <= SW'(sq3_r[0]) + SW'(sq3_r[1]) + SW'(sq3_r[2]);
    neg1_r  <= neg_nxt;
    neg2_r  <= neg1_r;
    neg3_r  <= neg2_r;
    neg4_r  <= neg3_r;
    side1_r <= side_i;
    side2_r <= side1_r;
    side3_r <= side2_r;
    side4_r <= side3_r;
  end

  // per-component divide and root
  for (genvar g = 0; g < 3; g++) begin : g_lane
    lar_lane u_lane (
      .clk    (clk),
      .a_sq_i (sq4_r[g]),
      .sum_i  (sum4_r),
      .q_o    (q[g])
    );
  end

  // valid, signs and side data wait for the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LANE_LAT; j++) dv_r[j] <= 1'b0;
    end else begin
      dv_r[0] <= v4_r;
      for (int j = 1; j < LANE_LAT; j++) dv_r[j] <= dv_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    dneg_r[0]  <= neg4_r;
    dside_r[0] <= side4_r;
    for (int j = 1; j < LANE_LAT; j++) begin
      dneg_r[j]  <= dneg_r[j-1];
      dside_r[j] <= dside_r[j-1];
    end
  end

  // reapply signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else begin
      vout_r <= dv_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u_r[i] <= dneg_r[LANE_LAT-1][i] ? -UW'(q[i]) : UW'(q[i]);
    end
    sout_r <= dside_r[LANE_LAT-1];
  end

  assign valid_o = vout_r;
  assign u_o     = u_r;
  assign side_o  = sout_r;

endmodule

`default_nettype wire

[hw/rtl/lar_cross.sv]
// lar_cross: two-stage cross product a x b of a Q12.12 and a Q1.14 vector.
// Uses lar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lar_cross (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  input  lar_pkg::vec_t  [2:0]  a_i,
  input  lar_pkg::unit_t [2:0]  b_i,
  input  lar_pkg::side_t        side_i,
  output logic                  valid_o,
  output lar_pkg::wide_t [2:0]  c_o,
  output lar_pkg::side_t        side_o
);
  import lar_pkg::*;

  logic        v1_r, v2_r;
  prod_t       p_r [6];
  side_t       side1_r, side2_r;
  wide_t [2:0] c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  // six products, then three differences
  always_ff @(posedge clk) begin
    p_r[0]  <= PW'(a_i[1]) * PW'(b_i[2]);
    p_r[1]  <= PW'(a_i[2]) * PW'(b_i[1]);
    p_r[2]  <= PW'(a_i[2]) * PW'(b_i[0]);
    p_r[3]  <= PW'(a_i[0]) * PW'(b_i[2]);
    p_r[4]  <= PW'(a_i[0]) * PW'(b_i[1]);
    p_r[5]  <= PW'(a_i[1]) * PW'(b_i[0]);
    side1_r <= side_i;
    c_r[0]  <= CW'(p_r[0]) - CW'(p_r[1]);
    c_r[1]  <= CW'(p_r[2]) - CW'(p_r[3]);
    c_r[2]  <= CW'(p_r[4]) - CW'(p_r[5]);
    side2_r <= side1_r;
  end

  assign valid_o = v2_r;
  assign c_o     = c_r;
  assign side_o  = side2_r;

endmodule

`default_nettype wire
